FILE: src/flow_table_double_hash_rate_macros.svh
// ----------------------------------------------------------------------------
// flow table assertion macros
// shared property forms for the flow table checks
// ----------------------------------------------------------------------------
`ifndef FLOW_TABLE_DOUBLE_HASH_RATE_MACROS_SVH
`define FLOW_TABLE_DOUBLE_HASH_RATE_MACROS_SVH

// same-cycle implication, checked outside reset
`define FTDH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FTDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ftdh_pkg.sv
// ----------------------------------------------------------------------------
// ftdh_pkg
// types and constants of the double hashing flow table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftdh_pkg;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [63:0] packet_total;
    logic [63:0] byte_total;
  } rec_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot;
    logic [63:0] packet_delta;
    logic [63:0] byte_delta;
  } res_t;

  typedef struct packed {
    logic        vld;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [63:0] packets;
    logic [63:0] bytes;
  } ent_t;

  localparam logic [1:0] ST_EXIST  = 2'd0;
  localparam logic [1:0] ST_NEW    = 2'd1;
  localparam logic [1:0] ST_FILT   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] REG_SRC_ADDR = 2'd0;
  localparam logic [1:0] REG_SRC_MASK = 2'd1;
  localparam logic [1:0] REG_DST_ADDR = 2'd2;
  localparam logic [1:0] REG_DST_MASK = 2'd3;

  localparam int unsigned MUL1 = 31;
  localparam int unsigned MUL2 = 37;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

FILE: src/ftdh_intf.sv
// ----------------------------------------------------------------------------
// ftdh channel interfaces
// valid/ready channels for flow records and table results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ftdh_rec_if import ftdh_pkg::*; ();
  logic valid;
  logic ready;
  rec_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ftdh_res_if import ftdh_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/flow_table_double_hash_rate.sv
// a record is filtered, hashed in ten folds of three phases each, then probed with a read
// and a check per probe, up to MAX_PROBES probes; filtered ones go straight to the output
// the fold chain through the reciprocal reducer of each hash sets the rate
// one record at a time; the next transfer is taken once the result is registered
// reset (synchronous, rst_n low) restores the filter registers, then a clearing
// pass over all TABLE_SIZE entries zeroes the table while no record is accepted
`timescale 1ns / 1ps
`default_nettype none
`include "flow_table_double_hash_rate_macros.svh"

// ----------------------------------------------------------------------------
// flow_table_double_hash_rate
// subnet filter, two polynomial hashes and a double hashing probe into a
// table memory with one read and one write port that holds per-flow cumulative counts
// ----------------------------------------------------------------------------
module flow_table_double_hash_rate import ftdh_pkg::*; #(
  parameter int TABLE_SIZE = 4096,
  parameter int MAX_PROBES = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  ftdh_rec_if.sink    in_rec,
  ftdh_res_if.source  out_res,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_idx,
  input  wire  [31:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int JW = $clog2(MAX_PROBES + 1);
  // fold operand: h * 31 or h * 37 + 16-bit value
  localparam int XW = ((IW > 16) ? IW : 16) + 7;
  localparam logic [32:0]   RECIP = 33'((64'd1 << 32) / TABLE_SIZE);
  localparam logic [XW-1:0] TS_X  = XW'(TABLE_SIZE);
  localparam logic [IW:0]   TS_S  = (IW + 1)'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST  = IW'(TABLE_SIZE - 1);

  // controller states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // fold phases
  localparam logic [1:0] PH_MUL = 2'd0;
  localparam logic [1:0] PH_RCP = 2'd1;
  localparam logic [1:0] PH_RED = 2'd2;

  // filter registers
  logic [31:0] src_match_r, src_mask_r, dst_match_r, dst_mask_r;

  logic [2:0]    state_r;
  logic [1:0]    ph_r;
  logic [3:0]    f_r;
  logic [JW-1:0] j_r;
  logic [IW-1:0] clr_r;
  logic [IW-1:0] s_r;
  logic [IW-1:0] h1_r, h2_r;
  logic [XW-1:0] x1_r, x2_r, q1_r, q2_r;
  rec_t          rec_r;
  res_t          res_r, out_r;
  logic          out_vld_r;

  // table memory
  ent_t          mem [TABLE_SIZE];
  ent_t          rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  ent_t          mem_wd;

  always_ff @(posedge clk) begin
    rd_q <= mem[s_r];
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_match_r <= '0;
      src_mask_r  <= ALL_ONES;
      dst_match_r <= '0;
      dst_mask_r  <= ALL_ONES;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SRC_ADDR: src_match_r <= cfg_wdata;
        REG_SRC_MASK: src_mask_r  <= cfg_wdata;
        REG_DST_ADDR: dst_match_r <= cfg_wdata;
        REG_DST_MASK: dst_mask_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // subnet filter on the incoming record
  logic pass;
  assign pass = ((src_match_r == '0) ||
                 ((in_rec.data.src_addr & src_mask_r) == (src_match_r & src_mask_r))) &&
                ((dst_match_r == '0) ||
                 ((in_rec.data.dst_addr & dst_mask_r) == (dst_match_r & dst_mask_r)));

  assign in_rec.ready = (state_r == S_IDLE);

  // value folded in at each step: address octets, then the ports
  logic [15:0] fv;
  always_comb begin
    case (f_r)
      4'd0:    fv = {8'd0, rec_r.src_addr[31:24]};
      4'd1:    fv = {8'd0, rec_r.src_addr[23:16]};
      4'd2:    fv = {8'd0, rec_r.src_addr[15:8]};
      4'd3:    fv = {8'd0, rec_r.src_addr[7:0]};
      4'd4:    fv = {8'd0, rec_r.dst_addr[31:24]};
      4'd5:    fv = {8'd0, rec_r.dst_addr[23:16]};
      4'd6:    fv = {8'd0, rec_r.dst_addr[15:8]};
      4'd7:    fv = {8'd0, rec_r.dst_addr[7:0]};
      4'd8:    fv = rec_r.src_port;
      default: fv = rec_r.dst_port;
    endcase
  end

  // fold arithmetic: multiply-add, reciprocal quotient, then remainder
  logic [XW-1:0]    x1_nxt, x2_nxt, t1, t2, r1, r2;
  logic [XW+32:0]   p1, p2;
  always_comb begin
    x1_nxt = XW'(h1_r) * XW'(MUL1) + XW'(fv);
    x2_nxt = XW'(h2_r) * XW'(MUL2) + XW'(fv);
    p1     = (XW + 33)'(x1_r) * (XW + 33)'(RECIP);
    p2     = (XW + 33)'(x2_r) * (XW + 33)'(RECIP);
    // quotient estimate is at most one low, so one correction step
    t1     = x1_r - XW'(q1_r * TS_X);
    t2     = x2_r - XW'(q2_r * TS_X);
    r1     = (t1 >= TS_X) ? t1 - TS_X : t1;
    r2     = (t2 >= TS_X) ? t2 - TS_X : t2;
  end

  // next probe slot: s + h2 with one wrap
  logic [IW:0]   step_sum;
  logic [IW-1:0] s_step;
  assign step_sum = {1'b0, s_r} + {1'b0, h2_r};
  assign s_step   = (step_sum >= TS_S) ? IW'(step_sum - TS_S) : step_sum[IW-1:0];

  // probe check on the registered memory word
  logic        hit, free_slot;
  logic [31:0] ports;
  assign ports     = {rec_r.src_port, rec_r.dst_port};
  assign free_slot = !rd_q.vld;
  assign hit       = rd_q.vld && (rd_q.protocol == rec_r.protocol) &&
                     (rd_q.src_addr == rec_r.src_addr) &&
                     (rd_q.dst_addr == rec_r.dst_addr) && (rd_q.ports == ports);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s_r;
    mem_wd = '{vld: 1'b1, protocol: rec_r.protocol, src_addr: rec_r.src_addr,
               dst_addr: rec_r.dst_addr, ports: ports,
               packets: rec_r.packet_total, bytes: rec_r.byte_total};
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (state_r == S_CHK && (hit || free_slot)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
      ph_r      <= PH_MUL;
      f_r       <= '0;
      j_r       <= '0;
    end else begin
      // output drains here except while a new result is being loaded
      if (out_vld_r && out_res.ready && state_r != S_OUT) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_rec.valid) begin
            rec_r <= in_rec.data;
            h1_r  <= '0;
            h2_r  <= '0;
            ph_r  <= PH_MUL;
            f_r   <= '0;
            j_r   <= '0;
            if (pass) begin
              state_r <= S_HASH;
            end else begin
              res_r   <= '{status: ST_FILT, slot: '0, packet_delta: '0, byte_delta: '0};
              state_r <= S_OUT;
            end
          end
        end
        S_HASH: begin
          case (ph_r)
            PH_MUL: begin
              x1_r <= x1_nxt;
              x2_r <= x2_nxt;
              ph_r <= PH_RCP;
            end
            PH_RCP: begin
              q1_r <= p1[32 +: XW];
              q2_r <= p2[32 +: XW];
              ph_r <= PH_RED;
            end
            default: begin
              ph_r <= PH_MUL;
              f_r  <= f_r + 1'b1;
              h1_r <= r1[IW-1:0];
              // after the last fold a zero second hash steps by one
              h2_r <= (f_r == 4'd9 && r2 == '0) ? IW'(1) : r2[IW-1:0];
              if (f_r == 4'd9) begin
                // first probe at h1
                s_r     <= r1[IW-1:0];
                state_r <= S_RD;
              end
            end
          endcase
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (hit) begin
            res_r   <= '{status: ST_EXIST, slot: 12'(s_r),
                         packet_delta: rec_r.packet_total - rd_q.packets,
                         byte_delta: rec_r.byte_total - rd_q.bytes};
            state_r <= S_OUT;
          end else if (free_slot) begin
            res_r   <= '{status: ST_NEW, slot: 12'(s_r),
                         packet_delta: rec_r.packet_total,
                         byte_delta: rec_r.byte_total};
            state_r <= S_OUT;
          end else if (j_r == JW'(MAX_PROBES - 1)) begin
            res_r   <= '{status: ST_FULL, slot: '0, packet_delta: '0, byte_delta: '0};
            state_r <= S_OUT;
          end else begin
            j_r     <= j_r + 1'b1;
            s_r     <= s_step;
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          // load the output register once the previous result has left
          if (!out_vld_r || out_res.ready) begin
            out_r     <= res_r;
            out_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid = out_vld_r;
  assign out_res.data  = out_r;

  // checks
  logic drop_out, drop_clean, wr_legal;
  assign drop_out   = out_res.valid &&
                      (out_res.data.status == ST_FILT || out_res.data.status == ST_FULL);
  assign drop_clean = (out_res.data.slot == '0) && (out_res.data.packet_delta == '0) &&
                      (out_res.data.byte_delta == '0);
  assign wr_legal   = (state_r == S_CLR) || (state_r == S_CHK);

  `FTDH_ASSERT_NOW(a_drop_zero, drop_out, drop_clean, "dropped record carries a slot or counts")
  `FTDH_ASSERT_NOW(a_write_when, mem_we, wr_legal, "table written outside clear or check")
  `FTDH_ASSERT_NOW(a_clear_blocks, state_r == S_CLR, !in_rec.ready, "record taken while clearing")
  `FTDH_ASSERT_NEXT(a_probe_read, state_r == S_RD, state_r == S_CHK, "probe read without check")

endmodule

`default_nettype wire
